[rtl/core/gsr_pkg.sv]
// Package for the GCR sector reader: item and result types, phase and status
// codes, fixed search constants and the GCR nibble decode functions.
// No dependencies.
package gsr_pkg;

  localparam logic [12:0] DataSyncWindow = 13'd4160;
  localparam logic [3:0]  SyncOnes       = 4'd10;
  localparam logic [12:0] WindowMax      = 13'h1fff;
  localparam logic [3:0]  OnesMax        = 4'hf;
  localparam logic [3:0]  GroupBits      = 4'd10;
  localparam logic [7:0]  HeaderMark     = 8'h08;
  localparam logic [7:0]  BlockMark      = 8'h07;
  localparam logic [8:0]  LastDataIdx    = 9'd256;
  localparam logic [8:0]  ChecksumIdx    = 9'd257;
  localparam logic [8:0]  EndIdx         = 9'd259;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'b00001,
    PH_HUNT_HDR  = 5'b00010,
    PH_READ_HDR  = 5'b00100,
    PH_HUNT_DATA = 5'b01000,
    PH_READ_DATA = 5'b10000
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_CHECKSUM  = 3'd1,
    ST_NO_MARK   = 3'd2,
    ST_NO_HEADER = 3'd3,
    ST_NO_SYNC   = 3'd4
  } status_e;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_BYTE  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic       is_start;
    logic [7:0] target_sector;
    logic [7:0] track_byte;
    logic       revolution_mark;
  } item_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    status_e     status;
    logic [15:0] disk_id;
    logic        last;
  } result_t;

  function automatic logic [7:0] gcr_nibble(logic [4:0] grp);
    logic [7:0] nib;
    case (grp)
      5'd9:    nib = 8'h08;
      5'd10:   nib = 8'h00;
      5'd11:   nib = 8'h01;
      5'd13:   nib = 8'h0c;
      5'd14:   nib = 8'h04;
      5'd15:   nib = 8'h05;
      5'd18:   nib = 8'h02;
      5'd19:   nib = 8'h03;
      5'd21:   nib = 8'h0f;
      5'd22:   nib = 8'h06;
      5'd23:   nib = 8'h07;
      5'd25:   nib = 8'h09;
      5'd26:   nib = 8'h0a;
      5'd27:   nib = 8'h0b;
      5'd29:   nib = 8'h0d;
      5'd30:   nib = 8'h0e;
      default: nib = 8'hff;
    endcase
    return nib;
  endfunction

  function automatic logic [7:0] gcr_decode(logic [9:0] bits);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = gcr_nibble(bits[9:5]);
    lo = gcr_nibble(bits[4:0]);
    if (hi == 8'hff || lo == 8'hff) begin
      return 8'hff;
    end
    return {hi[3:0], lo[3:0]};
  endfunction

endpackage

[rtl/core/gsr_front.sv]
// Front end of the GCR sector reader: accepts stream transactions, classifies
// each as a start command or a track byte and queues it for the back end.
// Depends on gsr_pkg.
module gsr_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [23:0]   s_axis_tdata_i,
  input  logic          s_axis_tuser_i,
  output logic          q_valid_o,
  input  logic          q_ready_i,
  output gsr_pkg::item_t q_item_o
);
  import gsr_pkg::*;

  item_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  item_t      item_in;

  always_comb begin
    item_in.is_start        = (s_axis_tuser_i == CMD_START);
    item_in.target_sector   = s_axis_tdata_i[7:0];
    item_in.track_byte      = s_axis_tdata_i[15:8];
    item_in.revolution_mark = s_axis_tdata_i[16];
  end

  assign s_axis_tready_o = (cnt_q != 2'd2);
  assign q_valid_o       = (cnt_q != 2'd0);
  assign q_item_o        = mem_q[rd_ptr_q];

  assign push = s_axis_tvalid_i && s_axis_tready_o;
  assign pop  = q_valid_o && q_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

[rtl/core/gsr_back.sv]
// Back end of the GCR sector reader: walks the eight bits of each queued byte
// through sync search, GCR decode and sector checks, and registers the result.
// Depends on gsr_pkg.
module gsr_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  output logic             q_ready_o,
  input  gsr_pkg::item_t   q_item_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output gsr_pkg::result_t res_o
);
  import gsr_pkg::*;

  phase_e      ph_q, ph_d;
  logic [3:0]  ones_q, ones_d;
  logic [9:0]  gs_q, gs_d;
  logic [3:0]  gbc_q, gbc_d;
  logic [8:0]  dc_q, dc_d;
  logic [7:0]  h0_q, h0_d;
  logic [7:0]  id_lo_q, id_lo_d;
  logic [7:0]  id_hi_q, id_hi_d;
  logic [7:0]  chk_q, chk_d;
  logic [12:0] win_q, win_d;
  logic [1:0]  mk_q, mk_d;
  logic [7:0]  sought_q, sought_d;
  logic        res_vld_q;
  result_t     res_q;
  logic        hit;
  result_t     res_d;
  logic        fire;

  assign q_ready_o   = !res_vld_q || res_ready_i;
  assign fire        = q_valid_i && q_ready_o;
  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

  always_comb begin
    logic       done;
    logic       bit_v;
    logic       sync;
    logic [7:0] b;
    logic [8:0] idx;
    ph_d     = ph_q;
    ones_d   = ones_q;
    gs_d     = gs_q;
    gbc_d    = gbc_q;
    dc_d     = dc_q;
    h0_d     = h0_q;
    id_lo_d  = id_lo_q;
    id_hi_d  = id_hi_q;
    chk_d    = chk_q;
    win_d    = win_q;
    mk_d     = mk_q;
    sought_d = sought_q;
    hit      = 1'b0;
    res_d    = '0;
    done     = 1'b0;
    bit_v    = 1'b0;
    sync     = 1'b0;
    b        = '0;
    idx      = '0;

    if (q_item_i.is_start) begin
      ph_d     = PH_HUNT_HDR;
      ones_d   = '0;
      gs_d     = '0;
      gbc_d    = '0;
      dc_d     = '0;
      h0_d     = '0;
      id_lo_d  = '0;
      id_hi_d  = '0;
      chk_d    = '0;
      win_d    = '0;
      mk_d     = '0;
      sought_d = q_item_i.target_sector;
      done     = 1'b1;
    end else if (ph_q == PH_IDLE) begin
      done = 1'b1;
    end else if (q_item_i.revolution_mark &&
                 (ph_q == PH_HUNT_HDR || ph_q == PH_READ_HDR)) begin
      if (mk_q != 2'd3) begin
        mk_d = mk_q + 2'd1;
      end
      if (mk_d >= 2'd2) begin
        hit          = 1'b1;
        res_d.kind   = KIND_STATUS;
        res_d.status = ST_NO_HEADER;
        res_d.last   = 1'b1;
        ph_d         = PH_IDLE;
        done         = 1'b1;
      end
    end

    for (int i = 7; i >= 0; i--) begin
      if (!done) begin
        bit_v = q_item_i.track_byte[3'(i)];
        sync  = !bit_v && (ones_d >= SyncOnes);
        unique case (ph_d)
          PH_HUNT_HDR: begin
            if (sync) begin
              ph_d  = PH_READ_HDR;
              gs_d  = '0;
              gbc_d = 4'd1;
              dc_d  = '0;
              win_d = 13'd1;
            end
          end
          PH_HUNT_DATA: begin
            if (win_d != WindowMax) begin
              win_d = win_d + 13'd1;
            end
            if (sync) begin
              ph_d  = PH_READ_DATA;
              gs_d  = '0;
              gbc_d = 4'd1;
              dc_d  = '0;
              chk_d = '0;
            end else if (win_d >= DataSyncWindow) begin
              hit           = 1'b1;
              res_d.kind    = KIND_STATUS;
              res_d.status  = ST_NO_SYNC;
              res_d.disk_id = {id_hi_d, id_lo_d};
              res_d.last    = 1'b1;
              ph_d          = PH_IDLE;
              done          = 1'b1;
            end
          end
          PH_READ_HDR, PH_READ_DATA: begin
            if (ph_d == PH_READ_HDR && win_d != WindowMax) begin
              win_d = win_d + 13'd1;
            end
            gs_d  = {gs_d[8:0], bit_v};
            gbc_d = gbc_d + 4'd1;
            if (gbc_d >= GroupBits) begin
              b     = gcr_decode(gs_d);
              idx   = dc_d;
              gbc_d = '0;
              dc_d  = dc_d + 9'd1;
              if (ph_d == PH_READ_HDR) begin
                if (idx == 9'd0) begin
                  h0_d = b;
                end else if (idx == 9'd2) begin
                  if (h0_d != HeaderMark || b != sought_d) begin
                    ph_d = PH_HUNT_HDR;
                  end
                end else if (idx == 9'd4) begin
                  id_lo_d = b;
                end else if (idx == 9'd5) begin
                  id_hi_d = b;
                  ph_d    = PH_HUNT_DATA;
                end
              end else begin
                if (idx == 9'd0) begin
                  h0_d = b;
                end else if (idx <= LastDataIdx) begin
                  chk_d            = chk_d ^ b;
                  hit              = 1'b1;
                  res_d.kind       = KIND_DATA;
                  res_d.data_byte  = b;
                  res_d.byte_index = 8'(idx - 9'd1);
                  res_d.status     = ST_OK;
                  res_d.disk_id    = {id_hi_d, id_lo_d};
                  res_d.last       = 1'b0;
                end else if (idx == ChecksumIdx) begin
                  chk_d = chk_d ^ b;
                end else if (idx >= EndIdx) begin
                  hit           = 1'b1;
                  res_d.kind    = KIND_STATUS;
                  res_d.status  = (h0_d != BlockMark) ? ST_NO_MARK
                                : ((chk_d != 8'd0) ? ST_CHECKSUM : ST_OK);
                  res_d.disk_id = {id_hi_d, id_lo_d};
                  res_d.last    = 1'b1;
                  ph_d          = PH_IDLE;
                  done          = 1'b1;
                end
              end
            end
          end
          default: begin
            done = 1'b1;
          end
        endcase
        if (!done) begin
          if (bit_v) begin
            if (ones_d != OnesMax) begin
              ones_d = ones_d + 4'd1;
            end
          end else begin
            ones_d = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q      <= PH_IDLE;
      ones_q    <= '0;
      gs_q      <= '0;
      gbc_q     <= '0;
      dc_q      <= '0;
      h0_q      <= '0;
      id_lo_q   <= '0;
      id_hi_q   <= '0;
      chk_q     <= '0;
      win_q     <= '0;
      mk_q      <= '0;
      sought_q  <= '0;
      res_vld_q <= 1'b0;
    end else begin
      if (fire) begin
        ph_q     <= ph_d;
        ones_q   <= ones_d;
        gs_q     <= gs_d;
        gbc_q    <= gbc_d;
        dc_q     <= dc_d;
        h0_q     <= h0_d;
        id_lo_q  <= id_lo_d;
        id_hi_q  <= id_hi_d;
        chk_q    <= chk_d;
        win_q    <= win_d;
        mk_q     <= mk_d;
        sought_q <= sought_d;
      end
      if (fire) begin
        res_vld_q <= hit;
      end else if (res_ready_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && hit) begin
      res_q <= res_d;
    end
  end

endmodule

[rtl/core/gcr_sector_reader_top.sv]
// GCR sector reader: finds one sector in a raw GCR byte stream and reads it.
// An accepted item is queued in the front end, decoded by the back end, and any
// result registered. Throughput: one item per cycle unless the output stalls; each
// byte's eight bits pass through one combinational chain of sync, shift and decode.
// Reset: asynchronous; empties the input queue and output register, phase idle.
// Depends on gsr_pkg, gsr_front and gsr_back.
module gcr_sector_reader_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // target_sector, track_byte, revolution_mark
  input  logic        s_axis_tuser,  // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // data_byte, byte_index, status, disk_id
  output logic        m_axis_tuser,  // kind
  output logic        m_axis_tlast
);
  import gsr_pkg::*;

  logic    q_valid;
  logic    q_ready;
  item_t   q_item;
  result_t res;

  gsr_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .q_valid_o       (q_valid),
    .q_ready_i       (q_ready),
    .q_item_o        (q_item)
  );

  gsr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_item_i    (q_item),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {5'd0, res.disk_id, res.status, res.byte_index, res.data_byte};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule
